// ===== design/descriptor_medoid_select_assert.svh =====
// Assertion macros for the descriptor medoid selection block.
// Needs nothing else; the including file provides clock and reset names.
`ifndef DESCRIPTOR_MEDOID_SELECT_ASSERT_SVH
`define DESCRIPTOR_MEDOID_SELECT_ASSERT_SVH
`ifndef ASSERT_OFF
`define DMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DMS_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");
`else
`define DMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DMS_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== design/dms_pkg.sv =====
// Package for the descriptor medoid selection block: constants, types, helpers.
// Depends on nothing.
`default_nettype none
package dms_pkg;
    localparam int MAX_DESC_DEF  = 32;
    localparam int DESC_BITS_DEF = 256;
    localparam int WORDS         = 4;
    localparam int WORD_W        = 64;
    localparam int DIST_W        = 9;
    localparam int PC_W          = 7;
    localparam int IDX_OUT_W     = 5;

    typedef logic [WORDS-1:0][WORD_W-1:0] desc_t;

    typedef struct packed {
        desc_t words;
        logic  last;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW_RD,
        ST_ROW_CAP,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_NEXT_ROW,
        ST_EMIT
    } back_state_t;

    // Bits of word w that lie below the descriptor length.
    function automatic logic [WORD_W-1:0] word_mask(input int w, input int bits);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            m[b] = (WORD_W * w + b) < bits;
        end
        return m;
    endfunction

    function automatic logic [PC_W-1:0] popcount(input logic [WORD_W-1:0] x);
        logic [PC_W-1:0] s;
        s = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            s = s + PC_W'(x[b]);
        end
        return s;
    endfunction
endpackage
`default_nettype wire

// ===== design/dms_channels.sv =====
// Handshake channels of the descriptor medoid selection block.
// Depends on nothing.
`default_nettype none
interface dms_desc_if;
    logic        valid;
    logic        ready;
    logic [63:0] desc_word0;
    logic [63:0] desc_word1;
    logic [63:0] desc_word2;
    logic [63:0] desc_word3;
    logic        is_last;
    modport source (output valid, desc_word0, desc_word1, desc_word2, desc_word3, is_last,
                    input ready);
    modport sink   (input valid, desc_word0, desc_word1, desc_word2, desc_word3, is_last,
                    output ready);
endinterface

interface dms_result_if;
    logic        valid;
    logic        ready;
    logic [4:0]  best_index;
    logic [8:0]  best_median;
    logic [63:0] best_word0;
    logic [63:0] best_word1;
    logic [63:0] best_word2;
    logic [63:0] best_word3;
    logic        overflowed;
    modport source (output valid, best_index, best_median, best_word0, best_word1,
                    best_word2, best_word3, overflowed, input ready);
    modport sink   (input valid, best_index, best_median, best_word0, best_word1,
                    best_word2, best_word3, overflowed, output ready);
endinterface
`default_nettype wire

// ===== design/descriptor_medoid_select.sv =====
// Top level of the descriptor medoid selection block.
// Uses dms_pkg, dms_channels, dms_front, dms_back and the assertion header.
`default_nettype none
`include "descriptor_medoid_select_assert.svh"
// Descriptors enter one per cycle while the back part is idle, through a
// two-entry queue. The item marked last starts the selection: for each of the
// N stored descriptors the median of its distance row is found by a nine-pass
// radix search, every pass rereading all N descriptors through the single
// store read port. Beyond the two items the queue holds, descriptors are not
// taken while the selection runs. The result waits in an output register
// until accepted.
module descriptor_medoid_select #(
    parameter int MAX_DESC  = dms_pkg::MAX_DESC_DEF,
    parameter int DESC_BITS = dms_pkg::DESC_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dms_desc_if.sink    desc,
    dms_result_if.source result
);
    dms_pkg::item_t q_item;
    logic           q_valid;
    logic           q_ready;

    dms_front #(.DESC_BITS(DESC_BITS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .desc    (desc),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_ready (q_ready)
    );

    dms_back #(.MAX_DESC(MAX_DESC)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .result  (result)
    );

    `DMS_ASSERT_NEVER(a_median_range, clk, rst_n, result.valid && result.best_median > 9'd256)
    `DMS_ASSERT_IMPLY(a_index_range, clk, rst_n, result.valid, int'(result.best_index) < MAX_DESC)
    `DMS_ASSERT_NEVER(a_queue_stall, clk, rst_n, q_ready && !q_valid && !desc.ready)
endmodule
`default_nettype wire

// ===== design/dms_front.sv =====
// Front part: accepts descriptor items, masks them to the descriptor length
// and holds them in a two-entry queue for the back part. Uses dms_pkg.
`default_nettype none
module dms_front #(
    parameter int DESC_BITS = dms_pkg::DESC_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    dms_desc_if.sink           desc,
    output dms_pkg::item_t     q_item,
    output logic               q_valid,
    input  wire logic          q_ready
);
    dms_pkg::item_t fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    dms_pkg::item_t in_item;

    assign desc.ready = (cnt_reg != 2'd2);
    assign push       = desc.valid && desc.ready;
    assign q_valid    = (cnt_reg != 2'd0);
    assign pop        = q_valid && q_ready;
    assign q_item     = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        in_item.words[0] = desc.desc_word0 & dms_pkg::word_mask(0, DESC_BITS);
        in_item.words[1] = desc.desc_word1 & dms_pkg::word_mask(1, DESC_BITS);
        in_item.words[2] = desc.desc_word2 & dms_pkg::word_mask(2, DESC_BITS);
        in_item.words[3] = desc.desc_word3 & dms_pkg::word_mask(3, DESC_BITS);
        in_item.last     = desc.is_last;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end
endmodule
`default_nettype wire

// ===== design/dms_back.sv =====
// Back part: descriptor store, per-row radix median search over recomputed
// Hamming distances, best-row tracking and the result register. Uses dms_pkg.
`default_nettype none
module dms_back #(
    parameter int MAX_DESC = dms_pkg::MAX_DESC_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire dms_pkg::item_t q_item,
    input  wire logic          q_valid,
    output logic               q_ready,
    dms_result_if.source       result
);
    localparam int IDXW = (MAX_DESC > 1) ? $clog2(MAX_DESC) : 1;
    localparam int CNTW = $clog2(MAX_DESC + 1);
    localparam int DW   = dms_pkg::DIST_W;

    dms_pkg::back_state_t state_reg, state_next;

    dms_pkg::desc_t mem [MAX_DESC];
    dms_pkg::desc_t mem_q;
    dms_pkg::desc_t cur_reg, best_words_reg;
    logic [dms_pkg::WORDS-1:0][dms_pkg::PC_W-1:0] pc_reg;

    logic [CNTW-1:0] count_reg, n_reg, j_reg, krem_reg, zcnt_reg;
    logic            ovf_reg;
    logic [IDXW-1:0] i_reg, best_idx_reg;
    logic [3:0]      bit_reg;
    logic [DW-1:0]   prefix_reg, best_med_reg;
    logic            v1_reg, v2_reg;

    logic            rd_en;
    logic [IDXW-1:0] rd_addr;
    logic            pop, store_ok, out_free;
    logic [CNTW-1:0] count_after;
    logic [DW-1:0]   ham_dist, hi_mask;
    logic            dist_zero_hit;

    assign pop         = q_valid && q_ready;
    assign store_ok    = (count_reg < CNTW'(MAX_DESC));
    assign count_after = store_ok ? count_reg + CNTW'(1) : count_reg;
    assign out_free    = !result.valid || result.ready;

    always_comb
    begin
        ham_dist = '0;
        for (int w = 0; w < dms_pkg::WORDS; w++)
        begin
            ham_dist = ham_dist + DW'(pc_reg[w]);
        end
        hi_mask       = DW'(10'h3FE << bit_reg);
        dist_zero_hit = (((ham_dist ^ prefix_reg) & hi_mask) == '0) && !ham_dist[bit_reg];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dms_pkg::ST_IDLE:
                if (pop && q_item.last)
                    state_next = dms_pkg::ST_ROW_RD;
            dms_pkg::ST_ROW_RD:
                state_next = dms_pkg::ST_ROW_CAP;
            dms_pkg::ST_ROW_CAP:
                state_next = dms_pkg::ST_SCAN;
            dms_pkg::ST_SCAN:
                if (j_reg == n_reg - CNTW'(1))
                    state_next = dms_pkg::ST_DRAIN;
            dms_pkg::ST_DRAIN:
                if (!v1_reg && !v2_reg)
                    state_next = dms_pkg::ST_DECIDE;
            dms_pkg::ST_DECIDE:
                state_next = (bit_reg == 4'd0) ? dms_pkg::ST_NEXT_ROW : dms_pkg::ST_SCAN;
            dms_pkg::ST_NEXT_ROW:
                state_next = (CNTW'(i_reg) == n_reg - CNTW'(1)) ?
                             dms_pkg::ST_EMIT : dms_pkg::ST_ROW_RD;
            dms_pkg::ST_EMIT:
                if (out_free)
                    state_next = dms_pkg::ST_IDLE;
            default:
                state_next = dms_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        q_ready = 1'b0;
        rd_en   = 1'b0;
        rd_addr = i_reg;
        unique case (state_reg)
            dms_pkg::ST_IDLE:
                q_ready = 1'b1;
            dms_pkg::ST_ROW_RD:
                rd_en = 1'b1;
            dms_pkg::ST_SCAN:
            begin
                rd_en   = 1'b1;
                rd_addr = IDXW'(j_reg);
            end
            default:
                q_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop && store_ok)
            mem[IDXW'(count_reg)] <= q_item.words;
        if (rd_en)
            mem_q <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        for (int w = 0; w < dms_pkg::WORDS; w++)
        begin
            pc_reg[w] <= dms_pkg::popcount(mem_q[w] ^ cur_reg[w]);
        end
        if (state_reg == dms_pkg::ST_ROW_CAP)
            cur_reg <= mem_q;
        if (state_reg == dms_pkg::ST_NEXT_ROW && (i_reg == '0 || prefix_reg < best_med_reg))
        begin
            best_words_reg <= cur_reg;
            best_med_reg   <= prefix_reg;
            best_idx_reg   <= i_reg;
        end
        if (state_reg == dms_pkg::ST_EMIT && out_free)
        begin
            result.best_index  <= dms_pkg::IDX_OUT_W'(best_idx_reg);
            result.best_median <= best_med_reg;
            result.best_word0  <= best_words_reg[0];
            result.best_word1  <= best_words_reg[1];
            result.best_word2  <= best_words_reg[2];
            result.best_word3  <= best_words_reg[3];
            result.overflowed  <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dms_pkg::ST_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            n_reg        <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            krem_reg     <= '0;
            zcnt_reg     <= '0;
            bit_reg      <= '0;
            prefix_reg   <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            result.valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == dms_pkg::ST_SCAN);
            v2_reg    <= v1_reg;
            if (v2_reg && dist_zero_hit)
                zcnt_reg <= zcnt_reg + CNTW'(1);
            if (result.valid && result.ready && !(state_reg == dms_pkg::ST_EMIT && out_free))
                result.valid <= 1'b0;
            unique case (state_reg)
                dms_pkg::ST_IDLE:
                    if (pop)
                    begin
                        count_reg <= count_after;
                        if (!store_ok)
                            ovf_reg <= 1'b1;
                        n_reg    <= count_after;
                        krem_reg <= (count_after - CNTW'(1)) >> 1;
                        i_reg    <= '0;
                    end
                dms_pkg::ST_ROW_CAP:
                begin
                    bit_reg    <= 4'd8;
                    prefix_reg <= '0;
                    krem_reg   <= (n_reg - CNTW'(1)) >> 1;
                    zcnt_reg   <= '0;
                    j_reg      <= '0;
                end
                dms_pkg::ST_SCAN:
                    j_reg <= j_reg + CNTW'(1);
                dms_pkg::ST_DECIDE:
                begin
                    // Set the bit to one if the median lies among the one-bit entries.
                    if (zcnt_reg <= krem_reg)
                    begin
                        prefix_reg[bit_reg] <= 1'b1;
                        krem_reg <= krem_reg - zcnt_reg;
                    end
                    zcnt_reg <= '0;
                    j_reg    <= '0;
                    bit_reg  <= bit_reg - 4'd1;
                end
                dms_pkg::ST_NEXT_ROW:
                    i_reg <= i_reg + IDXW'(1);
                dms_pkg::ST_EMIT:
                    if (out_free)
                    begin
                        result.valid <= 1'b1;
                        count_reg    <= '0;
                        ovf_reg      <= 1'b0;
                    end
                default:
                    j_reg <= j_reg;
            endcase
        end
    end
endmodule
`default_nettype wire
